// File: hw/rtl/stsi_pkg.sv
// Shared types and constants for the sorted table search and insert core.
`timescale 1ns / 1ps

package stsi_pkg;

  localparam int STATUS_W   = 3;
  localparam int OUT_IDX_W  = 9;
  localparam int IN_KEY_W   = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic REQ_SEARCH = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_SHIFT,
    ST_INS,
    ST_DONE
  } state_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_FOUND    = 3'd0,
    RES_BETWEEN  = 3'd1,
    RES_MISSING  = 3'd2,
    RES_INSERTED = 3'd3,
    RES_REJECTED = 3'd4
  } res_code_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      load;
    logic      probe_rd;
    logic      probe_upd;
    logic      shift_start;
    logic      shift_step;
    logic      ins_wr;
    logic      res_load;
    res_code_t res_code;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic req_insert;
    logic range_ok;
    logic key_eq;
    logic empty;
    logic full;
    logic sh_more;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/stsi_ctrl.sv
// Controller state machine: sequences search probes, the shift-up and the result.
`timescale 1ns / 1ps

module stsi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  stsi_pkg::sts_t  sts,
  output stsi_pkg::cmd_t  cmd
);

  stsi_pkg::state_t    state_r, state_nxt;
  stsi_pkg::res_code_t code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stsi_pkg::ST_IDLE;
      code_r  <= stsi_pkg::RES_MISSING;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // Next state and result code
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    case (state_r)
      stsi_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = stsi_pkg::ST_PROBE;
      end
      stsi_pkg::ST_PROBE: begin
        if (sts.range_ok) begin
          state_nxt = stsi_pkg::ST_CMP;
        end else if (!sts.req_insert) begin
          code_nxt  = sts.empty ? stsi_pkg::RES_MISSING : stsi_pkg::RES_BETWEEN;
          state_nxt = stsi_pkg::ST_DONE;
        end else if (sts.full) begin
          code_nxt  = stsi_pkg::RES_REJECTED;
          state_nxt = stsi_pkg::ST_DONE;
        end else begin
          state_nxt = stsi_pkg::ST_SHIFT;
        end
      end
      stsi_pkg::ST_CMP: begin
        if (sts.key_eq) begin
          code_nxt  = sts.req_insert ? stsi_pkg::RES_REJECTED : stsi_pkg::RES_FOUND;
          state_nxt = stsi_pkg::ST_DONE;
        end else begin
          state_nxt = stsi_pkg::ST_PROBE;
        end
      end
      stsi_pkg::ST_SHIFT: begin
        if (!sts.sh_more) state_nxt = stsi_pkg::ST_INS;
      end
      stsi_pkg::ST_INS: begin
        code_nxt  = stsi_pkg::RES_INSERTED;
        state_nxt = stsi_pkg::ST_DONE;
      end
      stsi_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = stsi_pkg::ST_IDLE;
      end
      default: state_nxt = stsi_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_tready        = 1'b0;
    cmd              = '0;
    cmd.res_code     = code_r;
    case (state_r)
      stsi_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      stsi_pkg::ST_PROBE: begin
        cmd.probe_rd    = sts.range_ok;
        cmd.shift_start = !sts.range_ok && sts.req_insert && !sts.full;
      end
      stsi_pkg::ST_CMP:   cmd.probe_upd  = 1'b1;
      stsi_pkg::ST_SHIFT: cmd.shift_step = sts.sh_more;
      stsi_pkg::ST_INS:   cmd.ins_wr     = 1'b1;
      stsi_pkg::ST_DONE:  cmd.res_load   = sts.out_free;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/stsi_dp.sv
// Datapath: key table memory, search bounds, shift pointer, count and result register.
`timescale 1ns / 1ps

module stsi_dp #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data,
  input  logic [stsi_pkg::IN_KEY_W-1:0]     in_tdata,
  input  logic                              in_tuser,
  input  stsi_pkg::cmd_t                    cmd,
  output stsi_pkg::sts_t                    sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [stsi_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [KEY_WIDTH-1:0] SIGN_BIT = KEY_WIDTH'(64'(1) << (KEY_WIDTH - 1));

  logic [KEY_WIDTH-1:0]       mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0]       rd_data_r;
  logic                       cmp_signed_r;
  logic                       req_insert_r;
  logic [KEY_WIDTH-1:0]       key_r;
  logic [KEY_WIDTH-1:0]       kv_r;
  logic [CNT_W-1:0]           lo_r;
  logic signed [CNT_W:0]      hi_r;
  logic [CNT_W-1:0]           mid_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           sh_r;
  logic                       pend_r;
  logic [IDX_W-1:0]           pend_addr_r;
  logic                       out_valid_r;
  logic [stsi_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [63:0]                key_ext;
  logic [KEY_WIDTH-1:0]       key_in;
  logic [KEY_WIDTH-1:0]       ev;
  logic [CNT_W:0]             mid_sum;
  logic [CNT_W-1:0]           mid;
  logic [CNT_W-1:0]           sh_dec;
  logic [IDX_W-1:0]           rd_addr;

  assign key_ext = 64'(in_tdata);
  assign key_in  = key_ext[KEY_WIDTH-1:0];
  // Flip the sign bit so an unsigned compare gives two's complement order
  assign ev      = cmp_signed_r ? (rd_data_r ^ SIGN_BIT) : rd_data_r;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r[CNT_W-1:0]};
  assign mid     = mid_sum[CNT_W:1];
  assign sh_dec  = sh_r - 1'b1;
  assign rd_addr = cmd.probe_rd ? mid[IDX_W-1:0] : sh_dec[IDX_W-1:0];

  always_comb begin
    sts.req_insert = req_insert_r;
    sts.range_ok   = $signed({1'b0, lo_r}) <= hi_r;
    sts.key_eq     = kv_r == ev;
    sts.empty      = count_r == '0;
    sts.full       = count_r == CNT_W'(TABLE_DEPTH);
    sts.sh_more    = sh_r > lo_r;
    sts.out_free   = !out_valid_r || out_tready;
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (pend_r) begin
      mem[pend_addr_r] <= rd_data_r;
    end else if (cmd.ins_wr) begin
      mem[lo_r[IDX_W-1:0]] <= key_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_signed_r <= 1'b0;
      count_r      <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) cmp_signed_r <= cfg_wr_data;
      if (cmd.ins_wr) count_r <= count_r + 1'b1;
      pend_r <= cmd.shift_step;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request, bounds and shift pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_insert_r <= in_tuser == stsi_pkg::REQ_INSERT;
      key_r        <= key_in;
      kv_r         <= cmp_signed_r ? (key_in ^ SIGN_BIT) : key_in;
      lo_r         <= '0;
      hi_r         <= $signed({1'b0, count_r} - 1'b1);
    end
    if (cmd.probe_rd) mid_r <= mid;
    if (cmd.probe_upd) begin
      if (kv_r > ev) begin
        lo_r <= mid_r + 1'b1;
      end else if (kv_r < ev) begin
        hi_r <= $signed({1'b0, mid_r} - 1'b1);
      end else begin
        lo_r <= mid_r;
        hi_r <= $signed({1'b0, mid_r});
      end
    end
    if (cmd.shift_start) begin
      sh_r <= count_r;
    end else if (cmd.shift_step) begin
      sh_r        <= sh_dec;
      pend_addr_r <= sh_r[IDX_W-1:0];
    end
    if (cmd.res_load) begin
      out_data_r <= {2'b00,
                     stsi_pkg::OUT_IDX_W'(count_r),
                     stsi_pkg::OUT_IDX_W'(hi_r),
                     stsi_pkg::OUT_IDX_W'(lo_r),
                     cmd.res_code};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hw/rtl/sorted_table_search_insert_core.sv
// Top level of the sorted key table: binary search and ordered insert.
`timescale 1ns / 1ps

// Keeps up to TABLE_DEPTH keys in ascending order in a simple dual-port memory
// (one write and one registered read per cycle). A search beat is accepted, then
// runs up to ceil(log2(count+1)) binary-search probes (each a read, then a compare),
// then decides and loads the result. An insert also moves up the (count - position)
// entries at and above the insert position and then writes the key.
// One request is in flight at a time; a new beat is taken while the previous
// result still waits in the output register. Table contents are undefined after
// reset; only entries below the count are read.
module sorted_table_search_insert_core #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // compare_signed
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [31:0] key
  input  logic        in_tuser,      // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata      // [2:0] status, [11:3] lower_index,
                                     // [20:12] upper_index, [29:21] entry_count
);

  stsi_pkg::cmd_t cmd;
  stsi_pkg::sts_t sts;

  stsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stsi_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a beat while a request is in flight");

  a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.res_load))
    else $error("result appeared without a result load");

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |-> !sts.full)
    else $error("insert written into a full table");

  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe_rd |-> sts.range_ok)
    else $error("probe issued with empty search range");

endmodule
